[design/swdh_pkg.sv]
// ----------------------------------------------------------------------------
// swdh_pkg
// Shared types and codes for the SWD host transaction engine.
// ----------------------------------------------------------------------------
`default_nettype none

package swdh_pkg;

  localparam logic [1:0] CMD_NONE       = 2'd0;
  localparam logic [1:0] CMD_LINE_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE      = 2'd2;
  localparam logic [1:0] CMD_READ       = 2'd3;

  localparam logic [2:0] ACK_OK    = 3'b001;
  localparam logic [2:0] ACK_WAIT  = 3'b010;
  localparam logic [2:0] ACK_FAULT = 3'b100;

  localparam logic [2:0] STATUS_OK         = 3'd0;
  localparam logic [2:0] STATUS_WAIT_OUT   = 3'd1;
  localparam logic [2:0] STATUS_FAULT      = 3'd2;
  localparam logic [2:0] STATUS_PARITY_ERR = 3'd3;
  localparam logic [2:0] STATUS_OTHER_ACK  = 3'd4;

  localparam logic [15:0] LINE_RESET_WORD    = 16'hE79E;
  localparam logic [7:0]  REQUEST_BASE       = 8'b1000_0001;
  localparam logic [15:0] MAX_ATTEMPTS_RESET = 16'd8;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  request_byte;
    logic [31:0] write_data;
    logic        swdio_in;
  } entry_t;

endpackage

`default_nettype wire

[design/swdh_in_if.sv]
// ----------------------------------------------------------------------------
// swdh_in_if
// Bit-period request channel: sampled line level and optional command.
// ----------------------------------------------------------------------------
`default_nettype none

interface swdh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        port_is_ap;
  logic [1:0]  reg_addr;
  logic [31:0] write_data;
  logic        swdio_in;

  modport source (
    output valid, cmd, port_is_ap, reg_addr, write_data, swdio_in,
    input  ready
  );

  modport sink (
    input  valid, cmd, port_is_ap, reg_addr, write_data, swdio_in,
    output ready
  );
endinterface

`default_nettype wire

[design/swdh_out_if.sv]
// ----------------------------------------------------------------------------
// swdh_out_if
// Bit-period result channel: line drive, progress flags and read word.
// ----------------------------------------------------------------------------
`default_nettype none

interface swdh_out_if;
  logic        valid;
  logic        ready;
  logic        swdio_out;
  logic        swdio_drive;
  logic        busy_res;
  logic        done_res;
  logic [2:0]  status;
  logic [31:0] read_data;

  modport source (
    output valid, swdio_out, swdio_drive, busy_res, done_res, status, read_data,
    input  ready
  );

  modport sink (
    input  valid, swdio_out, swdio_drive, busy_res, done_res, status, read_data,
    output ready
  );
endinterface

`default_nettype wire

[design/swdh_front.sv]
// ----------------------------------------------------------------------------
// swdh_front
// Accepts requests, builds the SWD request byte and queues the entries.
// ----------------------------------------------------------------------------
`default_nettype none

module swdh_front #(
  parameter int DEPTH = swdh_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  swdh_in_if.sink           item,
  output swdh_pkg::entry_t  head,
  output logic              head_valid,
  input  wire logic         pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  swdh_pkg::entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  swdh_pkg::entry_t decoded;
  logic             push;
  logic             rnw;
  logic             parity;

  always_comb begin
    rnw    = (item.cmd == swdh_pkg::CMD_READ);
    parity = item.port_is_ap ^ rnw ^ item.reg_addr[0] ^ item.reg_addr[1];
    decoded.cmd          = item.cmd;
    decoded.request_byte = swdh_pkg::REQUEST_BASE
                         | {6'd0, item.port_is_ap, 1'b0}
                         | {5'd0, rnw, 2'd0}
                         | {3'd0, item.reg_addr, 3'd0}
                         | {2'd0, parity, 5'd0};
    decoded.write_data   = item.write_data;
    decoded.swdio_in     = item.swdio_in;
  end

  assign item.ready = (count != CNT_W'(DEPTH));
  assign push       = item.valid && item.ready;
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/swdh_back.sv]
// ----------------------------------------------------------------------------
// swdh_back
// SWD bit sequencer: one queued request per cycle into the result register, unless the result register is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module swdh_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_wdata,
  input  wire swdh_pkg::entry_t  head,
  input  wire logic              head_valid,
  output logic                   pop,
  swdh_out_if.source             result
);

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_LR_ONES_A = 4'd1;
  localparam logic [3:0] PH_LR_MAGIC  = 4'd2;
  localparam logic [3:0] PH_LR_ONES_B = 4'd3;
  localparam logic [3:0] PH_LR_ZEROS  = 4'd4;
  localparam logic [3:0] PH_REQ       = 4'd5;
  localparam logic [3:0] PH_TRN_REQ   = 4'd6;
  localparam logic [3:0] PH_ACK       = 4'd7;
  localparam logic [3:0] PH_TRN_ACK   = 4'd8;
  localparam logic [3:0] PH_WDATA     = 4'd9;
  localparam logic [3:0] PH_RDATA     = 4'd10;
  localparam logic [3:0] PH_TRN_RD    = 4'd11;
  localparam logic [3:0] PH_IDLE8     = 4'd12;

  localparam logic [6:0] N_ONES  = 7'd60;
  localparam logic [6:0] N_MAGIC = 7'd16;
  localparam logic [6:0] N_ZEROS = 7'd4;
  localparam logic [6:0] N_REQ   = 7'd8;
  localparam logic [6:0] N_ACK   = 7'd3;
  localparam logic [6:0] N_DATA  = 7'd32;
  localparam logic [6:0] N_DATAP = 7'd33;
  localparam logic [6:0] N_IDLE  = 7'd8;

  logic [15:0] max_attempts;
  logic [3:0]  phase, phase_next;
  logic [6:0]  bit_count, bit_count_next;
  logic [7:0]  request_byte, request_byte_next;
  logic [31:0] data_shift, data_shift_next;
  logic        running_parity, running_parity_next;
  logic [2:0]  ack_bits, ack_bits_next;
  logic [15:0] attempts_left, attempts_left_next;
  logic        is_read, is_read_next;
  logic [31:0] last_read_word, last_read_word_next;

  logic        res_valid;
  logic        res_out, res_drive, res_busy, res_done;
  logic [2:0]  res_status;
  logic        o, drive, busy, done;
  logic [2:0]  stat;
  logic [6:0]  bc_inc;

  function automatic logic [2:0] final_status(input logic [2:0] ack, input logic rd,
                                              input logic par);
    if (ack == swdh_pkg::ACK_OK) begin
      return (rd && par) ? swdh_pkg::STATUS_PARITY_ERR : swdh_pkg::STATUS_OK;
    end else if (ack == swdh_pkg::ACK_WAIT) begin
      return swdh_pkg::STATUS_WAIT_OUT;
    end else if (ack == swdh_pkg::ACK_FAULT) begin
      return swdh_pkg::STATUS_FAULT;
    end
    return swdh_pkg::STATUS_OTHER_ACK;
  endfunction

  assign pop = head_valid && (!res_valid || result.ready);

  always_comb begin
    phase_next          = phase;
    bit_count_next      = bit_count;
    request_byte_next   = request_byte;
    data_shift_next     = data_shift;
    running_parity_next = running_parity;
    ack_bits_next       = ack_bits;
    attempts_left_next  = attempts_left;
    is_read_next        = is_read;
    last_read_word_next = last_read_word;
    o     = 1'b0;
    drive = 1'b0;
    busy  = 1'b1;
    done  = 1'b0;
    stat  = swdh_pkg::STATUS_OK;

    // command start: the first bit goes out in the same period
    if (phase == PH_IDLE && head.cmd != swdh_pkg::CMD_NONE) begin
      running_parity_next = 1'b0;
      ack_bits_next       = 3'd0;
      bit_count_next      = 7'd0;
      if (head.cmd == swdh_pkg::CMD_LINE_RESET) begin
        phase_next = PH_LR_ONES_A;
      end else begin
        is_read_next       = (head.cmd == swdh_pkg::CMD_READ);
        request_byte_next  = head.request_byte;
        data_shift_next    = head.write_data;
        attempts_left_next = (max_attempts != 16'd0) ? max_attempts : 16'd1;
        phase_next         = PH_REQ;
      end
    end

    bc_inc = bit_count_next + 7'd1;

    unique case (phase_next)
      PH_IDLE: begin
        busy = 1'b0;
      end
      PH_LR_ONES_A, PH_LR_ONES_B: begin
        drive = 1'b1;
        o     = 1'b1;
        if (bc_inc >= N_ONES) begin
          phase_next     = (phase_next == PH_LR_ONES_A) ? PH_LR_MAGIC : PH_LR_ZEROS;
          bit_count_next = 7'd0;
        end else begin
          bit_count_next = bc_inc;
        end
      end
      PH_LR_MAGIC: begin
        drive = 1'b1;
        o     = swdh_pkg::LINE_RESET_WORD[bit_count_next[3:0]];
        if (bc_inc >= N_MAGIC) begin
          phase_next     = PH_LR_ONES_B;
          bit_count_next = 7'd0;
        end else begin
          bit_count_next = bc_inc;
        end
      end
      PH_LR_ZEROS: begin
        drive = 1'b1;
        if (bc_inc >= N_ZEROS) begin
          done           = 1'b1;
          phase_next     = PH_IDLE;
          bit_count_next = 7'd0;
        end else begin
          bit_count_next = bc_inc;
        end
      end
      PH_REQ: begin
        drive = 1'b1;
        o     = request_byte_next[bit_count_next[2:0]];
        if (bc_inc >= N_REQ) begin
          phase_next     = PH_TRN_REQ;
          bit_count_next = 7'd0;
        end else begin
          bit_count_next = bc_inc;
        end
      end
      PH_TRN_REQ: begin
        ack_bits_next  = 3'd0;
        phase_next     = PH_ACK;
        bit_count_next = 7'd0;
      end
      PH_ACK: begin
        ack_bits_next = ack_bits_next | (3'(head.swdio_in) << bit_count_next[1:0]);
        if (bc_inc >= N_ACK) begin
          bit_count_next = 7'd0;
          if (is_read_next && ack_bits_next == swdh_pkg::ACK_OK) begin
            data_shift_next     = 32'd0;
            running_parity_next = 1'b0;
            phase_next          = PH_RDATA;
          end else begin
            phase_next = PH_TRN_ACK;
          end
        end else begin
          bit_count_next = bc_inc;
        end
      end
      PH_TRN_ACK: begin
        bit_count_next = 7'd0;
        if (ack_bits_next == swdh_pkg::ACK_WAIT && attempts_left_next > 16'd1) begin
          attempts_left_next = attempts_left_next - 16'd1;
          phase_next         = PH_REQ;
        end else if (ack_bits_next == swdh_pkg::ACK_OK && !is_read_next) begin
          running_parity_next = 1'b0;
          phase_next          = PH_WDATA;
        end else begin
          phase_next = PH_IDLE8;
        end
      end
      PH_WDATA: begin
        drive = 1'b1;
        if (bit_count_next < N_DATA) begin
          o                   = data_shift_next[bit_count_next[4:0]];
          running_parity_next = running_parity_next ^ o;
        end else begin
          o                   = running_parity_next;
          running_parity_next = 1'b0;
        end
        if (bc_inc >= N_DATAP) begin
          phase_next     = PH_IDLE8;
          bit_count_next = 7'd0;
        end else begin
          bit_count_next = bc_inc;
        end
      end
      PH_RDATA: begin
        running_parity_next = running_parity_next ^ head.swdio_in;
        if (bit_count_next < N_DATA) begin
          data_shift_next = data_shift_next
                          | (32'(head.swdio_in) << bit_count_next[4:0]);
        end else begin
          last_read_word_next = data_shift_next;
        end
        if (bc_inc >= N_DATAP) begin
          phase_next     = PH_TRN_RD;
          bit_count_next = 7'd0;
        end else begin
          bit_count_next = bc_inc;
        end
      end
      PH_TRN_RD: begin
        phase_next     = PH_IDLE8;
        bit_count_next = 7'd0;
      end
      PH_IDLE8: begin
        drive = 1'b1;
        if (bc_inc >= N_IDLE) begin
          done           = 1'b1;
          stat           = final_status(ack_bits_next, is_read_next, running_parity_next);
          phase_next     = PH_IDLE;
          bit_count_next = 7'd0;
        end else begin
          bit_count_next = bc_inc;
        end
      end
      default: begin
        busy           = 1'b0;
        phase_next     = PH_IDLE;
        bit_count_next = 7'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_attempts   <= swdh_pkg::MAX_ATTEMPTS_RESET;
      phase          <= PH_IDLE;
      bit_count      <= 7'd0;
      request_byte   <= 8'd0;
      data_shift     <= 32'd0;
      running_parity <= 1'b0;
      ack_bits       <= 3'd0;
      attempts_left  <= 16'd0;
      is_read        <= 1'b0;
      last_read_word <= 32'd0;
      res_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_attempts <= cfg_wdata;
      end
      if (pop) begin
        phase          <= phase_next;
        bit_count      <= bit_count_next;
        request_byte   <= request_byte_next;
        data_shift     <= data_shift_next;
        running_parity <= running_parity_next;
        ack_bits       <= ack_bits_next;
        attempts_left  <= attempts_left_next;
        is_read        <= is_read_next;
        last_read_word <= last_read_word_next;
      end
      res_valid <= pop || (res_valid && !result.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_out    <= drive & o;
      res_drive  <= drive;
      res_busy   <= busy;
      res_done   <= done;
      res_status <= stat;
    end
  end

  assign result.valid       = res_valid;
  assign result.swdio_out   = res_out;
  assign result.swdio_drive = res_drive;
  assign result.busy_res    = res_busy;
  assign result.done_res    = res_done;
  assign result.status      = res_status;
  assign result.read_data   = last_read_word;

endmodule

`default_nettype wire

[design/swd_host_transaction_engine_core.sv]
// ----------------------------------------------------------------------------
// swd_host_transaction_engine_core
// An accepted request is queued, then the sequencer step writes its result into the result register.
// Throughput: one bit period per cycle while neither side stalls, set by the combinational sequencer step.
// The request queue and the result register let either side stall alone.
// Reset (rst, synchronous): queue empty, sequencer idle, max_attempts = 8.
// ----------------------------------------------------------------------------
`default_nettype none

module swd_host_transaction_engine_core #(
  parameter int QUEUE_DEPTH = swdh_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  swdh_in_if.sink          item,
  swdh_out_if.source       result
);

  swdh_pkg::entry_t head;
  logic             head_valid;
  logic             pop;

  swdh_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  swdh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .result     (result)
  );

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("sequencer took an entry from an empty queue");

  a_released_low: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.swdio_drive) |-> !result.swdio_out)
    else $error("swdio_out high while line released");

  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status != swdh_pkg::STATUS_OK) |-> result.done_res)
    else $error("status reported outside the last bit period");

  a_done_is_busy: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.done_res) |-> result.busy_res)
    else $error("done without busy");

endmodule

`default_nettype wire

[test/swd_host_transaction_engine_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swd_host_transaction_engine_core_tb
// Self-checking bench for the SWD host engine. Every bit period is sent as
// one request. A bench-side line model answers acks and read data. A
// cycle-accurate predictor queues the expected line levels, flags and
// status, and the checker compares each result against them in order.
// ----------------------------------------------------------------------------

module swd_host_transaction_engine_core_tb;

  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_PERIODS = 540;
  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RESET_ONES     = 60;

  typedef enum logic [3:0] {
    S_IDLE, S_RST_ONES_A, S_RST_MAGIC, S_RST_ONES_B, S_RST_ZEROS,
    S_REQUEST, S_TRN_REQUEST, S_ACK, S_TRN_ACK, S_WRITE_DATA,
    S_READ_DATA, S_TRN_READ, S_IDLE_BITS
  } swd_phase_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        port_is_ap;
    logic [1:0]  reg_addr;
    logic [31:0] write_data;
    logic        swdio_in;
  } bit_period_t;

  typedef struct packed {
    logic        swdio_out;
    logic        swdio_drive;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  status;
    logic [31:0] read_data;
  } line_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  swdh_in_if  item_if ();
  swdh_out_if result_if ();

  swd_host_transaction_engine_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_if),
    .result    (result_if)
  );

  always #5 clk = ~clk;

  // predictor state
  swd_phase_t  sq_state;
  int unsigned sq_count;
  logic [7:0]  sq_request;
  logic [31:0] sq_shift;
  logic        sq_parity;
  logic [2:0]  sq_ack;
  logic [15:0] sq_attempts;
  logic        sq_is_read;
  logic [31:0] sq_last_word;
  logic [15:0] sq_max_attempts;

  line_result_t expected_lines[$];

  // target side of the wire
  logic [2:0]  ack_plan[$];
  logic [31:0] rd_word;
  logic        rd_flip;

  int mismatches    = 0;
  int results_seen  = 0;
  int periods_sent  = 0;
  int burst_left    = 0;
  bit sender_quiet  = 1'b0;
  int idle_cycles   = 0;

  function automatic void enter_phase(swd_phase_t s);
    sq_state = s;
    sq_count = 0;
  endfunction

  function automatic void swd_reset_model();
    sq_max_attempts = swdh_pkg::MAX_ATTEMPTS_RESET;
    sq_state        = S_IDLE;
    sq_count        = 0;
    sq_request      = '0;
    sq_shift        = '0;
    sq_parity       = 1'b0;
    sq_ack          = '0;
    sq_attempts     = '0;
    sq_is_read      = 1'b0;
    sq_last_word    = '0;
  endfunction

  function automatic logic [2:0] swd_final_status();
    if (sq_ack == swdh_pkg::ACK_OK)
      return (sq_is_read && sq_parity) ? swdh_pkg::STATUS_PARITY_ERR : swdh_pkg::STATUS_OK;
    if (sq_ack == swdh_pkg::ACK_WAIT)
      return swdh_pkg::STATUS_WAIT_OUT;
    if (sq_ack == swdh_pkg::ACK_FAULT)
      return swdh_pkg::STATUS_FAULT;
    return swdh_pkg::STATUS_OTHER_ACK;
  endfunction

  function automatic line_result_t swd_bit_period(bit_period_t it);
    line_result_t r;
    logic [7:0]   rq;
    logic         lvl;
    r = '0;
    lvl = 1'b0;
    r.busy_res = 1'b1;
    if (sq_state == S_IDLE && it.cmd != swdh_pkg::CMD_NONE) begin
      sq_parity = 1'b0;
      sq_ack = '0;
      if (it.cmd == swdh_pkg::CMD_LINE_RESET) begin
        enter_phase(S_RST_ONES_A);
      end else begin
        sq_is_read = (it.cmd == swdh_pkg::CMD_READ);
        rq = swdh_pkg::REQUEST_BASE
           | {3'b000, it.reg_addr, sq_is_read, it.port_is_ap, 1'b0};
        rq[5] = ^rq[4:1];
        sq_request = rq;
        sq_shift = it.write_data;
        sq_attempts = (sq_max_attempts == 16'd0) ? 16'd1 : sq_max_attempts;
        enter_phase(S_REQUEST);
      end
    end

    case (sq_state)
      S_IDLE: begin
        r.busy_res = 1'b0;
      end
      S_RST_ONES_A, S_RST_ONES_B: begin
        r.swdio_drive = 1'b1;
        lvl = 1'b1;
        sq_count++;
        if (sq_count >= RESET_ONES) begin
          if (sq_state == S_RST_ONES_A) enter_phase(S_RST_MAGIC);
          else enter_phase(S_RST_ZEROS);
        end
      end
      S_RST_MAGIC: begin
        r.swdio_drive = 1'b1;
        lvl = swdh_pkg::LINE_RESET_WORD[sq_count[3:0]];
        sq_count++;
        if (sq_count >= 16) enter_phase(S_RST_ONES_B);
      end
      S_RST_ZEROS: begin
        r.swdio_drive = 1'b1;
        sq_count++;
        if (sq_count >= 4) begin
          r.done_res = 1'b1;
          enter_phase(S_IDLE);
        end
      end
      S_REQUEST: begin
        r.swdio_drive = 1'b1;
        lvl = sq_request[sq_count[2:0]];
        sq_count++;
        if (sq_count >= 8) enter_phase(S_TRN_REQUEST);
      end
      S_TRN_REQUEST: begin
        sq_ack = '0;
        enter_phase(S_ACK);
      end
      S_ACK: begin
        sq_ack[sq_count] = it.swdio_in;
        sq_count++;
        if (sq_count >= 3) begin
          if (sq_is_read && sq_ack == swdh_pkg::ACK_OK) begin
            sq_shift = '0;
            sq_parity = 1'b0;
            enter_phase(S_READ_DATA);
          end else begin
            enter_phase(S_TRN_ACK);
          end
        end
      end
      S_TRN_ACK: begin
        if (sq_ack == swdh_pkg::ACK_WAIT && sq_attempts > 16'd1) begin
          sq_attempts = sq_attempts - 16'd1;
          enter_phase(S_REQUEST);
        end else if (sq_ack == swdh_pkg::ACK_OK && !sq_is_read) begin
          sq_parity = 1'b0;
          enter_phase(S_WRITE_DATA);
        end else begin
          enter_phase(S_IDLE_BITS);
        end
      end
      S_WRITE_DATA: begin
        r.swdio_drive = 1'b1;
        if (sq_count < 32) begin
          lvl = sq_shift[sq_count];
          sq_parity ^= lvl;
        end else begin
          lvl = sq_parity;
          sq_parity = 1'b0;
        end
        sq_count++;
        if (sq_count >= 33) enter_phase(S_IDLE_BITS);
      end
      S_READ_DATA: begin
        sq_parity ^= it.swdio_in;
        if (sq_count < 32) sq_shift[sq_count] = it.swdio_in;
        else sq_last_word = sq_shift;
        sq_count++;
        if (sq_count >= 33) enter_phase(S_TRN_READ);
      end
      S_TRN_READ: begin
        enter_phase(S_IDLE_BITS);
      end
      S_IDLE_BITS: begin
        r.swdio_drive = 1'b1;
        sq_count++;
        if (sq_count >= 8) begin
          r.done_res = 1'b1;
          r.status = swd_final_status();
          enter_phase(S_IDLE);
        end
      end
      default: begin
        r.busy_res = 1'b0;
        enter_phase(S_IDLE);
      end
    endcase

    r.swdio_out = r.swdio_drive ? lvl : 1'b0;
    r.read_data = sq_last_word;
    return r;
  endfunction

  // level the target puts on the line for the coming bit period
  function automatic logic target_level();
    if (sq_state == S_ACK && ack_plan.size() > 0)
      return ack_plan[0][sq_count];
    if (sq_state == S_READ_DATA)
      return (sq_count < 32) ? rd_word[sq_count] : (^rd_word ^ rd_flip);
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("tb: mismatch at result %0d: %s", results_seen, msg);
  endtask

  task automatic drive_period(input bit_period_t it);
    swd_phase_t  was;
    int unsigned cnt;
    int          gap;
    if (burst_left == 0) begin
      gap = sender_quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    item_if.valid      <= 1'b1;
    item_if.cmd        <= it.cmd;
    item_if.port_is_ap <= it.port_is_ap;
    item_if.reg_addr   <= it.reg_addr;
    item_if.write_data <= it.write_data;
    item_if.swdio_in   <= it.swdio_in;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    burst_left--;
    periods_sent++;
    was = sq_state;
    cnt = sq_count;
    expected_lines.push_back(swd_bit_period(it));
    if (was == S_ACK && cnt == 2 && ack_plan.size() > 0)
      void'(ack_plan.pop_front());
  endtask

  task automatic drain_results();
    item_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_max_attempts(input logic [15:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sq_max_attempts = value;
  endtask

  // one command from idle until the engine is idle again; busy_pct sets how
  // often a stray command rides along while busy
  task automatic swd_command(input logic [1:0] cmd, input logic ap, input logic [1:0] addr,
                             input logic [31:0] wdata, input logic [31:0] rword,
                             input logic flip, input int busy_pct);
    bit_period_t it;
    rd_word = rword;
    rd_flip = flip;
    it.cmd        = cmd;
    it.port_is_ap = ap;
    it.reg_addr   = addr;
    it.write_data = wdata;
    it.swdio_in   = target_level();
    drive_period(it);
    while (sq_state != S_IDLE) begin
      it.cmd        = ($urandom_range(0, 99) < busy_pct) ? 2'($urandom_range(1, 3))
                                                         : swdh_pkg::CMD_NONE;
      it.port_is_ap = 1'($urandom_range(0, 1));
      it.reg_addr   = 2'($urandom_range(0, 3));
      it.write_data = $urandom;
      it.swdio_in   = target_level();
      drive_period(it);
    end
    ack_plan.delete();
  endtask

  task automatic idle_ticks(input int n);
    bit_period_t it;
    repeat (n) begin
      it.cmd        = swdh_pkg::CMD_NONE;
      it.port_is_ap = 1'($urandom_range(0, 1));
      it.reg_addr   = 2'($urandom_range(0, 3));
      it.write_data = $urandom;
      it.swdio_in   = 1'($urandom_range(0, 1));
      drive_period(it);
    end
  endtask

  function automatic logic [2:0] odd_ack();
    logic [2:0] a;
    a = 3'($urandom_range(0, 7));
    while (a == swdh_pkg::ACK_OK || a == swdh_pkg::ACK_WAIT || a == swdh_pkg::ACK_FAULT)
      a = 3'($urandom_range(0, 7));
    return a;
  endfunction

  function automatic logic [15:0] pick_attempts();
    case ($urandom_range(0, 6))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      3: return swdh_pkg::MAX_ATTEMPTS_RESET;
      4: return 16'hFFFF;
      default: return 16'($urandom_range(1, 5));
    endcase
  endfunction

  task automatic test_idle_ticks();
    idle_ticks(5);
  endtask

  task automatic test_line_reset();
    swd_command(swdh_pkg::CMD_LINE_RESET, 1'b0, 2'd0, '0, '0, 1'b0, 30);
  endtask

  task automatic test_write_ok();
    ack_plan = '{swdh_pkg::ACK_OK};
    swd_command(swdh_pkg::CMD_WRITE, 1'b0, 2'd0, 32'h0000_0000, '0, 1'b0, 0);
    ack_plan = '{swdh_pkg::ACK_OK};
    swd_command(swdh_pkg::CMD_WRITE, 1'b1, 2'd3, 32'hFFFF_FFFF, '0, 1'b0, 0);
  endtask

  task automatic test_read_ok();
    ack_plan = '{swdh_pkg::ACK_OK};
    swd_command(swdh_pkg::CMD_READ, 1'b0, 2'd1, '0, 32'hFFFF_FFFF, 1'b0, 0);
    ack_plan = '{swdh_pkg::ACK_OK};
    swd_command(swdh_pkg::CMD_READ, 1'b1, 2'd2, '0, 32'h0000_0000, 1'b0, 0);
  endtask

  task automatic test_read_parity();
    ack_plan = '{swdh_pkg::ACK_OK};
    swd_command(swdh_pkg::CMD_READ, 1'b1, 2'd0, '0, 32'hA5C3_0F17, 1'b1, 0);
  endtask

  task automatic test_wait_retry();
    ack_plan = '{swdh_pkg::ACK_WAIT, swdh_pkg::ACK_WAIT, swdh_pkg::ACK_OK};
    swd_command(swdh_pkg::CMD_WRITE, 1'b1, 2'd1, 32'h1234_5678, '0, 1'b0, 0);
  endtask

  // eight WAITs exhaust the reset attempt count
  task automatic test_default_attempts();
    ack_plan = '{swdh_pkg::ACK_WAIT, swdh_pkg::ACK_WAIT, swdh_pkg::ACK_WAIT,
                 swdh_pkg::ACK_WAIT, swdh_pkg::ACK_WAIT, swdh_pkg::ACK_WAIT,
                 swdh_pkg::ACK_WAIT, swdh_pkg::ACK_WAIT, swdh_pkg::ACK_OK};
    swd_command(swdh_pkg::CMD_READ, 1'b0, 2'd3, '0, 32'hDEAD_BEEF, 1'b0, 0);
  endtask

  task automatic test_wait_exhausted();
    set_max_attempts(16'd2);
    ack_plan = '{swdh_pkg::ACK_WAIT, swdh_pkg::ACK_WAIT, swdh_pkg::ACK_OK};
    swd_command(swdh_pkg::CMD_READ, 1'b1, 2'd1, '0, 32'h0F0F_0F0F, 1'b0, 0);
    set_max_attempts(16'd1);
    ack_plan = '{swdh_pkg::ACK_WAIT, swdh_pkg::ACK_OK};
    swd_command(swdh_pkg::CMD_WRITE, 1'b0, 2'd2, 32'h8000_0001, '0, 1'b0, 0);
  endtask

  task automatic test_zero_attempts();
    set_max_attempts(16'd0);
    ack_plan = '{swdh_pkg::ACK_WAIT, swdh_pkg::ACK_OK};
    swd_command(swdh_pkg::CMD_READ, 1'b0, 2'd2, '0, 32'h5555_AAAA, 1'b0, 0);
  endtask

  task automatic test_max_attempts_extreme();
    set_max_attempts(16'hFFFF);
    ack_plan = '{swdh_pkg::ACK_WAIT, swdh_pkg::ACK_WAIT, swdh_pkg::ACK_WAIT,
                 swdh_pkg::ACK_OK};
    swd_command(swdh_pkg::CMD_READ, 1'b1, 2'd3, '0, 32'h7FFF_FFFE, 1'b0, 0);
  endtask

  task automatic test_fault();
    ack_plan = '{swdh_pkg::ACK_FAULT};
    swd_command(swdh_pkg::CMD_WRITE, 1'b1, 2'd0, 32'hCAFE_F00D, '0, 1'b0, 0);
    ack_plan = '{swdh_pkg::ACK_FAULT};
    swd_command(swdh_pkg::CMD_READ, 1'b0, 2'd0, '0, 32'h1111_2222, 1'b0, 0);
  endtask

  task automatic test_other_ack();
    ack_plan = '{3'b000};
    swd_command(swdh_pkg::CMD_WRITE, 1'b0, 2'd1, 32'h0BAD_0BAD, '0, 1'b0, 0);
    ack_plan = '{3'b111};
    swd_command(swdh_pkg::CMD_READ, 1'b1, 2'd2, '0, 32'h3333_4444, 1'b0, 0);
  endtask

  task automatic test_command_while_busy();
    ack_plan = '{swdh_pkg::ACK_OK};
    swd_command(swdh_pkg::CMD_READ, 1'b0, 2'd1, '0, 32'h9ABC_DEF0, 1'b0, 100);
  endtask

  task automatic random_access(input bit plan_it, input int busy_pct);
    logic [1:0] c;
    int         waits;
    int         pick;
    c = $urandom_range(0, 1) ? swdh_pkg::CMD_READ : swdh_pkg::CMD_WRITE;
    ack_plan.delete();
    if (plan_it) begin
      waits = $urandom_range(0, 4);
      repeat (waits) ack_plan.push_back(swdh_pkg::ACK_WAIT);
      pick = $urandom_range(0, 99);
      if (pick < 60) ack_plan.push_back(swdh_pkg::ACK_OK);
      else if (pick < 75) ack_plan.push_back(swdh_pkg::ACK_FAULT);
      else ack_plan.push_back(odd_ack());
    end
    swd_command(c, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom, $urandom,
                $urandom_range(0, 99) < 20, busy_pct);
  endtask

  task automatic test_random();
    int start;
    int n;
    int kind;
    start = periods_sent;
    n = 0;
    while (periods_sent - start < RANDOM_PERIODS) begin
      if (n % 4 == 0) set_max_attempts(pick_attempts());
      if ($urandom_range(0, 3) == 0) sender_quiet = ~sender_quiet;
      kind = $urandom_range(0, 99);
      if (kind < 72) random_access(1'b1, $urandom_range(0, 20));
      else if (kind < 87) random_access(1'b0, 30);
      else if (kind < 92)
        swd_command(swdh_pkg::CMD_LINE_RESET, 1'b0, 2'd0, '0, '0, 1'b0, 20);
      else idle_ticks($urandom_range(1, 5));
      n++;
    end
    sender_quiet = 1'b0;
  endtask

  // receiver stall pattern
  initial begin
    logic [15:0] pat;
    int          pos;
    result_if.ready <= 1'b0;
    pat = 16'hFFFF;
    pos = 0;
    forever begin
      @(posedge clk);
      result_if.ready <= pat[pos];
      pos++;
      if (pos == 16) begin
        pos = 0;
        if ($urandom_range(0, 3) == 0) pat = 16'hFFFF;
        else pat = 16'($urandom) | 16'h0001;
      end
    end
  end

  always @(posedge clk) begin
    line_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_lines.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_lines.pop_front();
        if (result_if.swdio_out !== want.swdio_out)
          report_mismatch($sformatf("swdio_out %b, want %b", result_if.swdio_out,
                                    want.swdio_out));
        if (result_if.swdio_drive !== want.swdio_drive)
          report_mismatch($sformatf("swdio_drive %b, want %b", result_if.swdio_drive,
                                    want.swdio_drive));
        if (result_if.busy_res !== want.busy_res)
          report_mismatch($sformatf("busy_res %b, want %b", result_if.busy_res,
                                    want.busy_res));
        if (result_if.done_res !== want.done_res)
          report_mismatch($sformatf("done_res %b, want %b", result_if.done_res,
                                    want.done_res));
        if (result_if.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", result_if.status, want.status));
        if (result_if.read_data !== want.read_data)
          report_mismatch($sformatf("read_data %h, want %h", result_if.read_data,
                                    want.read_data));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    item_if.valid      <= 1'b0;
    item_if.cmd        <= swdh_pkg::CMD_NONE;
    item_if.port_is_ap <= 1'b0;
    item_if.reg_addr   <= '0;
    item_if.write_data <= '0;
    item_if.swdio_in   <= 1'b0;
    swd_reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_ticks();
    test_line_reset();
    test_write_ok();
    test_read_ok();
    test_read_parity();
    test_wait_retry();
    test_default_attempts();
    test_fault();
    test_other_ack();
    test_command_while_busy();
    test_wait_exhausted();
    test_zero_attempts();
    test_max_attempts_extreme();
    test_random();

    drain_results();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
